### hw/rtl/positional_ordered_list_core_assert.svh
// Assertion macros for the positional ordered list core.
// Each check is clocked on clk and is held off while rst_n is low.
`ifndef POSITIONAL_ORDERED_LIST_CORE_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Implication check, held off during reset
`define POL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Plain invariant, held off during reset
`define POL_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define POL_ASSERT(lbl, prop, msg)
`define POL_ASSERT_ALWAYS(lbl, expr, msg)
`endif

`endif

### hw/rtl/pol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pol_pkg;

  // Default list capacity
  localparam int unsigned POL_DEPTH = 32;

  // Beat field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned FPOS_W   = 6;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned IN_DW    = 48;
  localparam int unsigned OUT_DW   = 48;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DUMP   = 2'd3
  } pol_op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_BOUNDS   = 3'd2,
    STAT_NOTFOUND = 3'd3,
    STAT_FULL     = 3'd4
  } pol_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_SR_RD,
    S_SR_CMP,
    S_DP_RD,
    S_DP_EMIT,
    S_RESP
  } pol_state_t;

endpackage
`default_nettype wire

### hw/rtl/positional_ordered_list_core.sv
// Positional ordered list: holds up to DEPTH signed 32-bit values in one
// memory with a single write port and a registered read port, driven by a
// small sequencer. One input beat is taken at a time; in_tready is low
// until the last result beat of that item has been loaded into the output
// register. An insert moves each entry at or above its slot one up, a read
// then a write each, then writes the value; a delete moves the entries
// above its slot down alike; a search compares entries from the start; a
// dump emits each entry, holding while the output is occupied. Errors
// (empty, out of bounds, full) go straight to the response. No clearing
// pass is needed after reset: only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none
`include "positional_ordered_list_core_assert.svh"
module positional_ordered_list_core #(
  parameter int unsigned DEPTH = pol_pkg::POL_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // op [1:0], position [9:2], value [41:10], zero [47:42]
  input  wire logic [pol_pkg::IN_DW-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // status [2:0], found_position [8:3], entry_value [40:9],
  // entry_count [46:41], zero [47]
  output logic [pol_pkg::OUT_DW-1:0]       out_tdata,
  output logic                             out_tlast
);
  import pol_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Sequencer and working registers
  pol_state_t            state_r, state_nxt;
  pol_op_t               op_r, op_nxt;
  logic [VAL_W-1:0]      val_r, val_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         ptr_r, ptr_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  pol_status_t           res_status_r, res_status_nxt;
  logic [FPOS_W-1:0]     res_pos_r, res_pos_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  pol_status_t           out_status_r, out_status_nxt;
  logic [FPOS_W-1:0]     out_pos_r, out_pos_nxt;
  logic [VAL_W-1:0]      out_val_r, out_val_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_load;
  logic                  out_free;

  // Memory ports
  logic [VAL_W-1:0]      mem [DEPTH];
  logic [VAL_W-1:0]      rd_data_r;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VAL_W-1:0]      wr_data;

  // Beat decode
  pol_op_t               in_op;
  logic [POS_W-1:0]      in_pos;
  logic [VAL_W-1:0]      in_val;
  logic                  in_acc;
  logic [POS_W:0]        pos_w;
  logic [POS_W:0]        cnt_w;
  logic                  ins_rng;
  logic                  del_rng;
  logic                  is_full;
  logic                  is_empty;
  logic [CW-1:0]         ins_idx;
  logic [CW-1:0]         del_idx;
  logic [CW-1:0]         ptr_inc;
  logic [CW-1:0]         ptr_inc2;
  logic [CW-1:0]         ptr_dec;
  logic [CW-1:0]         del_idx_inc;
  logic                  hit;

  assign in_op    = pol_op_t'(in_tdata[1:0]);
  assign in_pos   = in_tdata[9:2];
  assign in_val   = in_tdata[41:10];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Range checks against the current count
  assign pos_w    = {1'b0, in_pos};
  assign cnt_w    = (POS_W + 1)'(count_r);
  assign ins_rng  = (in_pos == '0) || (pos_w <= cnt_w + 9'd1);
  assign del_rng  = (in_pos == '0) || (pos_w <= cnt_w);
  assign is_full  = (count_r >= CW'(DEPTH));
  assign is_empty = (count_r == '0);
  assign ins_idx  = (in_pos == '0) ? count_r : CW'(pos_w - 9'd1);
  assign del_idx  = (in_pos == '0) ? (count_r - CW'(1)) : CW'(pos_w - 9'd1);
  assign del_idx_inc = del_idx + CW'(1);
  assign ptr_inc  = ptr_r + CW'(1);
  assign ptr_inc2 = ptr_r + CW'(2);
  assign ptr_dec  = ptr_r - CW'(1);
  assign hit      = (rd_data_r == val_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_INSERT: begin
              if (!ins_rng || is_full) state_nxt = S_RESP;
              else if (count_r > ins_idx) state_nxt = S_SH_RD;
              else state_nxt = S_PUT;
            end
            OP_DELETE: begin
              if (is_empty || !del_rng) state_nxt = S_RESP;
              else if (del_idx_inc < count_r) state_nxt = S_SH_RD;
              else state_nxt = S_RESP;
            end
            OP_SEARCH: state_nxt = is_empty ? S_RESP : S_SR_RD;
            OP_DUMP:   state_nxt = is_empty ? S_RESP : S_DP_RD;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_SH_RD: state_nxt = S_SH_WR;
      S_SH_WR: begin
        if (op_r == OP_INSERT) begin
          state_nxt = (ptr_dec > idx_r) ? S_SH_RD : S_PUT;
        end else begin
          state_nxt = (ptr_inc2 < count_r) ? S_SH_RD : S_RESP;
        end
      end
      S_PUT:    state_nxt = S_RESP;
      S_SR_RD:  state_nxt = S_SR_CMP;
      S_SR_CMP: begin
        if (hit || (ptr_inc == count_r)) state_nxt = S_RESP;
        else state_nxt = S_SR_RD;
      end
      S_DP_RD:  state_nxt = S_DP_EMIT;
      S_DP_EMIT: begin
        if (out_free) state_nxt = (ptr_inc == count_r) ? S_IDLE : S_DP_RD;
      end
      S_RESP: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory ports and output loading
  always_comb begin
    op_nxt         = op_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    ptr_nxt        = ptr_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    rd_en          = 1'b0;
    rd_addr        = ptr_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = ptr_r[AW-1:0];
    wr_data        = rd_data_r;
    out_load       = 1'b0;
    out_status_nxt = res_status_r;
    out_pos_nxt    = res_pos_r;
    out_val_nxt    = '0;
    out_last_nxt   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt         = in_op;
          val_nxt        = in_val;
          res_pos_nxt    = '0;
          res_status_nxt = STAT_OK;
          ptr_nxt        = '0;
          unique case (in_op)
            OP_INSERT: begin
              if (!ins_rng) res_status_nxt = STAT_BOUNDS;
              else if (is_full) res_status_nxt = STAT_FULL;
              idx_nxt = ins_idx;
              ptr_nxt = count_r;
            end
            OP_DELETE: begin
              if (is_empty) res_status_nxt = STAT_EMPTY;
              else if (!del_rng) res_status_nxt = STAT_BOUNDS;
              else if (!(del_idx_inc < count_r)) count_nxt = count_r - CW'(1);
              ptr_nxt = del_idx;
            end
            OP_SEARCH, OP_DUMP: begin
              if (is_empty) res_status_nxt = STAT_EMPTY;
            end
            default: res_status_nxt = STAT_OK;
          endcase
        end
      end
      S_SH_RD: begin
        // Fetch the neighbour that moves into the slot at ptr
        rd_en   = 1'b1;
        rd_addr = (op_r == OP_INSERT) ? ptr_dec[AW-1:0] : ptr_inc[AW-1:0];
      end
      S_SH_WR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[AW-1:0];
        wr_data = rd_data_r;
        if (op_r == OP_INSERT) begin
          ptr_nxt = ptr_dec;
        end else begin
          ptr_nxt = ptr_inc;
          if (!(ptr_inc2 < count_r)) count_nxt = count_r - CW'(1);
        end
      end
      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[AW-1:0];
        wr_data   = val_r;
        count_nxt = count_r + CW'(1);
      end
      S_SR_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr_r[AW-1:0];
      end
      S_SR_CMP: begin
        ptr_nxt = ptr_inc;
        if (hit) begin
          res_pos_nxt = FPOS_W'(ptr_inc);
        end else if (ptr_inc == count_r) begin
          res_status_nxt = STAT_NOTFOUND;
        end
      end
      S_DP_RD: begin
        rd_en   = 1'b1;
        rd_addr = ptr_r[AW-1:0];
      end
      S_DP_EMIT: begin
        // Emit one entry per beat, hold while the output is occupied
        out_status_nxt = STAT_OK;
        out_pos_nxt    = FPOS_W'(ptr_inc);
        out_val_nxt    = rd_data_r;
        out_last_nxt   = (ptr_inc == count_r);
        if (out_free) begin
          out_load = 1'b1;
          ptr_nxt  = ptr_inc;
        end
      end
      S_RESP: begin
        out_load = out_free;
      end
      default: out_load = 1'b0;
    endcase
  end

  assign out_cnt_nxt   = CNT_W'(count_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    ptr_r        <= ptr_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_pos_r    <= out_pos_nxt;
      out_val_r    <= out_val_nxt;
      out_cnt_r    <= out_cnt_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // Entry store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_val_r, out_pos_r, out_status_r};

  // Checks
  `POL_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(DEPTH), "count exceeds capacity")
  `POL_ASSERT(a_accept_busy, in_acc |=> (state_r != S_IDLE), "accepted beat left sequencer idle")
  `POL_ASSERT(a_count_step, !$stable(count_r) |-> ((count_r == $past(count_r) + CW'(1)) || (count_r + CW'(1) == $past(count_r))), "count moved by more than one")
  `POL_ASSERT(a_partial_ok, (out_tvalid && !out_tlast) |-> (out_tdata[2:0] == STAT_OK), "non-final result without ok status")

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import pol_pkg::*;

  // One expected result beat
  typedef struct {
    pol_status_t status;
    logic [5:0]  found_pos;
    logic [31:0] entry_val;
    logic [5:0]  entry_cnt;
    logic        last;
  } list_beat_t;

  // Shadow copy of the list and the queue of beats it predicts
  class list_scoreboard;
    logic [31:0]  store [POL_DEPTH];
    int unsigned  fill;
    list_beat_t   want_beats [$];
    int           errors;
    int           items;
    int           beats;
    int           full_hits;

    function new();
      fill = 0;
      errors = 0;
      items = 0;
      beats = 0;
      full_hits = 0;
    endfunction

    function int unsigned size();
      return fill;
    endfunction

    function int unsigned pending();
      return want_beats.size();
    endfunction

    function logic [31:0] entry_at(int unsigned idx);
      return store[idx];
    endfunction

    function void push_beat(pol_status_t st, int unsigned fpos, logic [31:0] val,
                            logic last);
      list_beat_t b;
      b.status    = st;
      b.found_pos = fpos[5:0];
      b.entry_val = val;
      b.entry_cnt = fill[5:0];
      b.last      = last;
      want_beats.push_back(b);
    endfunction

    function pol_status_t place_value(int unsigned pos, logic [31:0] val);
      int unsigned idx;
      if (pos == 0) begin
        idx = fill;
      end else if (pos <= fill + 1) begin
        idx = pos - 1;
      end else begin
        return STAT_BOUNDS;
      end
      // range check first, then capacity
      if (fill >= POL_DEPTH) begin
        full_hits++;
        return STAT_FULL;
      end
      for (int unsigned i = fill; i > idx; i--) store[i] = store[i-1];
      store[idx] = val;
      fill++;
      return STAT_OK;
    endfunction

    function pol_status_t remove_value(int unsigned pos);
      int unsigned idx;
      if (fill == 0) return STAT_EMPTY;
      if (pos == 0) begin
        idx = fill - 1;
      end else if (pos <= fill) begin
        idx = pos - 1;
      end else begin
        return STAT_BOUNDS;
      end
      for (int unsigned i = idx; i + 1 < fill; i++) store[i] = store[i+1];
      fill--;
      return STAT_OK;
    endfunction

    // Work out the result beats of one accepted input beat
    function void note_item(pol_op_t op, logic [7:0] pos, logic [31:0] val);
      int hit;
      items++;
      case (op)
        OP_INSERT: push_beat(place_value(32'(pos), val), 0, '0, 1'b1);
        OP_DELETE: push_beat(remove_value(32'(pos)), 0, '0, 1'b1);
        OP_SEARCH: begin
          if (fill == 0) begin
            push_beat(STAT_EMPTY, 0, '0, 1'b1);
          end else begin
            hit = -1;
            for (int i = 0; i < fill; i++) begin
              if (hit < 0 && store[i] == val) hit = i;
            end
            if (hit >= 0) push_beat(STAT_OK, hit + 1, '0, 1'b1);
            else push_beat(STAT_NOTFOUND, 0, '0, 1'b1);
          end
        end
        default: begin
          if (fill == 0) begin
            push_beat(STAT_EMPTY, 0, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < fill; i++)
              push_beat(STAT_OK, i + 1, store[i], (i + 1 == fill));
          end
        end
      endcase
    endfunction

    function void compare(string fname, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        // cap the log on a badly broken block
        if (errors <= 100)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      end
    endfunction

    // Compare one accepted result beat with the oldest expectation
    function void check_result(logic [OUT_DW-1:0] data, logic last);
      list_beat_t b;
      beats++;
      if (want_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual %0h", $time, data);
        return;
      end
      b = want_beats.pop_front();
      compare("status", 32'(b.status), 32'(data[2:0]));
      compare("found_position", 32'(b.found_pos), 32'(data[8:3]));
      compare("entry_value", b.entry_val, data[40:9]);
      compare("entry_count", 32'(b.entry_cnt), 32'(data[46:41]));
      compare("pad", 32'd0, 32'(data[47]));
      compare("last", 32'(b.last), 32'(last));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic                out_tlast;

  list_scoreboard      sb = new();
  logic                quiet = 1'b0;
  logic                calm = 1'b0;
  int                  stall_left = 0;
  int                  calm_timer = 0;
  int                  dead_cycles = 0;

  positional_ordered_list_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Check result beats and stall the result side in bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    calm_timer <= calm_timer + 1;
    if (calm_timer % 80 == 79) calm <= ($urandom_range(0, 2) == 0);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog: give up after a long stretch with no beat moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      dead_cycles <= 0;
    end else begin
      dead_cycles <= dead_cycles + 1;
      if (dead_cycles >= 3000) begin
        $display("%0t: timeout with %0d beats outstanding", $time, sb.pending());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offer one input beat, with an optional gap first, and wait for it to go
  task automatic send_item(pol_op_t op, logic [7:0] pos, logic [31:0] val);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, val, pos, op};
    do @(posedge clk); while (!in_tready);
    sb.note_item(op, pos, val);
  endtask

  // Hold the sender until the list has answered everything
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3, 4, 5: return $urandom;
      default: return $urandom_range(0, 15) - 8;
    endcase
  endfunction

  // Build one random item, shaped by the grow or shrink phase
  task automatic send_random(logic grow);
    int unsigned r;
    int unsigned n;
    pol_op_t     op;
    logic [7:0]  pos;
    logic [31:0] val;
    r = $urandom_range(0, 99);
    n = sb.size();
    if (grow) op = (r < 70) ? OP_INSERT : (r < 80) ? OP_DELETE : (r < 93) ? OP_SEARCH : OP_DUMP;
    else op = (r < 15) ? OP_INSERT : (r < 75) ? OP_DELETE : (r < 92) ? OP_SEARCH : OP_DUMP;
    if ($urandom_range(0, 99) < 15 || op == OP_DUMP) begin
      pos = 8'($urandom_range(0, 255));
    end else if (op == OP_INSERT) begin
      pos = 8'($urandom_range(0, n + 1));
    end else begin
      pos = 8'($urandom_range(0, n));
    end
    val = pick_value();
    if (op == OP_SEARCH && n > 0 && $urandom_range(0, 1) == 0)
      val = sb.entry_at($urandom_range(0, n - 1));
    send_item(op, pos, val);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list, bounds and each end of the list
    send_item(OP_DUMP,   8'd0,   32'd0);
    send_item(OP_DELETE, 8'd0,   32'd0);
    send_item(OP_SEARCH, 8'd1,   32'd0);
    send_item(OP_INSERT, 8'd2,   32'd1);
    send_item(OP_INSERT, 8'd255, 32'd2);
    send_item(OP_INSERT, 8'd0,   32'h7fff_ffff);
    send_item(OP_INSERT, 8'd1,   32'h8000_0000);
    send_item(OP_INSERT, 8'd3,   32'd0);
    send_item(OP_INSERT, 8'd2,   32'hffff_ffff);
    send_item(OP_INSERT, 8'd6,   32'd3);
    send_item(OP_SEARCH, 8'd0,   32'd0);
    send_item(OP_SEARCH, 8'd0,   32'd12345);
    send_item(OP_DUMP,   8'd255, 32'hffff_ffff);
    send_item(OP_DELETE, 8'd5,   32'd0);
    send_item(OP_DELETE, 8'd2,   32'd0);
    send_item(OP_DELETE, 8'd0,   32'd0);
    send_item(OP_DELETE, 8'd1,   32'd0);
    send_item(OP_DELETE, 8'd255, 32'd0);
    send_item(OP_DUMP,   8'd0,   32'd0);
    // Duplicates: search must report the lowest position
    send_item(OP_INSERT, 8'd0,   32'd5);
    send_item(OP_INSERT, 8'd1,   32'd5);
    send_item(OP_SEARCH, 8'd0,   32'd5);
    send_item(OP_DELETE, 8'd0,   32'd0);
    send_item(OP_DELETE, 8'd0,   32'd0);
    drain_results();

    // Alternate grow and shrink phases so the list fills and empties
    for (int i = 0; i < 400; i++) begin
      if (i == 340) quiet = 1'b1;
      if (i % 100 == 99) drain_results();
      send_random((i / 70) % 2 == 0);
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Covered %0d list operations and %0d result beats.", sb.items, sb.beats);
    $display("Inserts refused on a full list: %0d.", sb.full_hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/pol_pkg.sv
hw/rtl/positional_ordered_list_core.sv
sim/testbench.sv
